// ===== rtl/core/gcet_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gray-coded event timer: shared definitions
// Operation codes, register offsets, control bit positions and the request
// bundle passed from the input stage to the timer core.
// ----------------------------------------------------------------------------
package gcet_pkg;

	// Width of the register window offset and of a bus word.
	localparam int ADDR_BITS = 12;
	localparam int WORD_BITS = 32;

	// Kind of request carried on the input channel.
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	// Register offsets within the window.
	localparam logic [ADDR_BITS-1:0] OFF_CNT_LO   = 12'h000;
	localparam logic [ADDR_BITS-1:0] OFF_CNT_HI   = 12'h004;
	localparam logic [ADDR_BITS-1:0] OFF_CAP_LO   = 12'h008;
	localparam logic [ADDR_BITS-1:0] OFF_CAP_HI   = 12'h00C;
	localparam logic [ADDR_BITS-1:0] OFF_MATCH_LO = 12'h010;
	localparam logic [ADDR_BITS-1:0] OFF_MATCH_HI = 12'h014;
	localparam logic [ADDR_BITS-1:0] OFF_CTRL     = 12'h01C;

	// Control register bit positions.
	localparam int CTRL_FLAG_BIT = 0;
	localparam int CTRL_EN_BIT   = 1;

	// One request as held in the input register.
	typedef struct packed {
		logic [1:0]           op;
		logic [ADDR_BITS-1:0] addr;
		logic [WORD_BITS-1:0] wdata;
	} req_t;

endpackage
`default_nettype wire

// ===== rtl/core/gcet_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gray-coded event timer: state and register logic
// Holds the counter, match and control state and works out, in one pass,
// the read value and the next state for the request presented to it.
// ----------------------------------------------------------------------------
module gcet_core #(
	parameter int COUNT_BITS = 42
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            step,
	input  gcet_pkg::req_t                 req,
	output logic [gcet_pkg::WORD_BITS-1:0] rd_data,
	output logic                           irq_next
);
	import gcet_pkg::*;

	localparam int HI_BITS = COUNT_BITS - WORD_BITS;

	// Gray to binary: each binary bit is the parity of the Gray bits at and above it.
	function automatic logic [COUNT_BITS-1:0] gray_decode(input logic [COUNT_BITS-1:0] g);
		logic [COUNT_BITS-1:0] b;
		for (int i = 0; i < COUNT_BITS; i++) begin
			b[i] = ^(g >> i);
		end
		return b;
	endfunction

	localparam logic [COUNT_BITS-1:0] MATCH_BIN_RST = gray_decode({COUNT_BITS{1'b1}});

	logic [COUNT_BITS-1:0] count_q, count_d, count_inc, count_gray;
	logic [WORD_BITS-1:0]  match_lo_q, match_lo_d;
	logic [HI_BITS-1:0]    match_hi_q, match_hi_d;
	logic [COUNT_BITS-1:0] match_bin_q, match_bin_d;
	logic                  flag_q, flag_d;
	logic                  en_q, en_d;
	logic                  armed_q, armed_d;
	logic                  rearm, fire;
	op_t                   op;

	assign op         = op_t'(req.op);
	assign count_inc  = count_q + 1'b1;
	assign count_gray = count_q ^ (count_q >> 1);

	// Register reads return the state as it stands before this request.
	always_comb begin
		rd_data = '0;
		if (op == OP_READ) begin
			case (req.addr)
				OFF_CNT_LO:   rd_data = count_gray[WORD_BITS-1:0];
				OFF_CNT_HI:   rd_data = WORD_BITS'(count_gray[COUNT_BITS-1:WORD_BITS]);
				OFF_CAP_LO:   rd_data = '0;
				OFF_CAP_HI:   rd_data = '0;
				OFF_MATCH_LO: rd_data = match_lo_q;
				OFF_MATCH_HI: rd_data = WORD_BITS'(match_hi_q);
				OFF_CTRL: begin
					rd_data[CTRL_FLAG_BIT] = flag_q;
					rd_data[CTRL_EN_BIT]   = en_q;
				end
				default:      rd_data = '0;
			endcase
		end
	end

	// Ticks advance the counter; writes update match and control.
	always_comb begin
		count_d    = count_q;
		match_lo_d = match_lo_q;
		match_hi_d = match_hi_q;
		flag_d     = flag_q;
		en_d       = en_q;
		rearm      = 1'b0;
		fire       = 1'b0;
		case (op)
			OP_TICK: begin
				count_d = count_inc;
				if (armed_q && (count_inc == match_bin_q)) begin
					fire   = 1'b1;
					flag_d = 1'b1;
				end
			end
			OP_WRITE: begin
				case (req.addr)
					OFF_MATCH_LO: begin
						match_lo_d = req.wdata;
						rearm      = 1'b1;
					end
					OFF_MATCH_HI: begin
						match_hi_d = req.wdata[HI_BITS-1:0];
						rearm      = 1'b1;
					end
					OFF_CTRL: begin
						if (req.wdata[CTRL_FLAG_BIT]) begin
							flag_d = 1'b0;
						end
						en_d  = req.wdata[CTRL_EN_BIT];
						rearm = 1'b1;
					end
					default: begin
						rearm = 1'b0;
					end
				endcase
			end
			default: begin
				fire = 1'b0;
			end
		endcase
	end

	// Binary copy of the match value and the compare arming.
	assign match_bin_d = gray_decode({match_hi_d, match_lo_d});

	always_comb begin
		armed_d = armed_q;
		if (rearm) begin
			armed_d = en_d && (match_bin_d > count_q);
		end else if (fire) begin
			armed_d = 1'b0;
		end
	end

	assign irq_next = flag_d & en_d;

	// State registers, updated once per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			match_lo_q  <= '1;
			match_hi_q  <= '1;
			match_bin_q <= MATCH_BIN_RST;
			flag_q      <= 1'b0;
			en_q        <= 1'b0;
			armed_q     <= 1'b0;
		end else if (step) begin
			count_q     <= count_d;
			match_lo_q  <= match_lo_d;
			match_hi_q  <= match_hi_d;
			match_bin_q <= match_bin_d;
			flag_q      <= flag_d;
			en_q        <= en_d;
			armed_q     <= armed_d;
		end
	end

	// The compare is only ever armed with the interrupt enabled.
	a_armed_needs_en: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> en_q)
		else $error("compare armed while interrupt disabled");

	// An armed compare always has its match still ahead of the count.
	a_armed_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> (match_bin_q > count_q))
		else $error("compare armed with match not ahead of count");

	// A tick that reaches the match sets the flag and disarms.
	a_fire_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (op == OP_TICK) && armed_q && (count_inc == match_bin_q))
		|=> (flag_q && !armed_q))
		else $error("matching tick did not raise the flag");

endmodule
`default_nettype wire

// ===== rtl/core/gray_coded_event_timer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gray-coded event timer
// Free-running counter with a Gray-coded register view, a match compare and
// a level interrupt, driven by a stream of tick, read and write requests.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while the output is not
// stalled and returns one result per request, in order, from the output
// register. A request is held in an input register; the timer state is
// updated and the result is formed in the single cycle that moves it into the
// output register, so that the next request sees the updated state at once.
// A stalled output holds its result and stalls the input only once the input
// register is also full. read_data carries the register value for reads and
// zero otherwise; irq_level is the interrupt line after the request.
module gray_coded_event_timer #(
	parameter int COUNT_BITS = 42
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire  [1:0]                     op,
	input  wire  [gcet_pkg::ADDR_BITS-1:0] addr,
	input  wire  [gcet_pkg::WORD_BITS-1:0] wdata,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [gcet_pkg::WORD_BITS-1:0] read_data,
	output logic                           irq_level
);
	import gcet_pkg::*;

	logic                 valid_s1;
	req_t                 req_s1;
	logic                 advance;
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] read_data_q;
	logic                 irq_q;
	logic [WORD_BITS-1:0] rd_data;
	logic                 irq_next;

	// A held request moves on when the output register is free or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1.op    <= op;
			req_s1.addr  <= addr;
			req_s1.wdata <= wdata;
		end
	end

	gcet_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.req      (req_s1),
		.rd_data  (rd_data),
		.irq_next (irq_next)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= rd_data;
			irq_q       <= irq_next;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign irq_level = irq_q;

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the Gray-coded event timer
// Sends tick, read and write requests through the valid/stall input channel
// and checks every result against a cycle-free prediction of the timer state.
// Both channels idle at random, and the match compare is steered so that it
// fires, misses and disarms many times.
// ----------------------------------------------------------------------------
module testbench;

	import gcet_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 5;
	localparam int COUNT_BITS      = 42;
	localparam int HIGH_BITS       = COUNT_BITS - 32;
	localparam int RANDOM_REQUESTS = 1950;
	localparam int SETTLE_CYCLES   = 16;
	localparam int MAX_REPORTS     = 10;

	// The one operation code that the package leaves unnamed.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Expected content of one result.
	typedef struct packed {
		logic [WORD_BITS-1:0] data;
		logic                 irq;
	} timer_reply_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           op = 2'd0;
	logic [ADDR_BITS-1:0] addr = '0;
	logic [WORD_BITS-1:0] wdata = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [WORD_BITS-1:0] read_data;
	logic                 irq_level;

	// Predicted timer state.
	logic [COUNT_BITS-1:0] tmr_count;
	logic [31:0]           match_gray_lo;
	logic [HIGH_BITS-1:0]  match_gray_hi;
	logic [COUNT_BITS-1:0] match_bin;
	logic                  flag;
	logic                  irq_en;
	logic                  armed;

	timer_reply_t expected_replies[$];
	int error_count = 0;
	int replies_checked = 0;
	int useful_requests = 0;
	bit sender_busy = 1'b1;
	bit receiver_busy = 1'b1;

	gray_coded_event_timer #(
		.COUNT_BITS(COUNT_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.addr      (addr),
		.wdata     (wdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.read_data (read_data),
		.irq_level (irq_level)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Safety net: a hung handshake ends the run here.
	initial begin
		#4_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [COUNT_BITS-1:0] binary_to_gray(input logic [COUNT_BITS-1:0] b);
		return b ^ (b >> 1);
	endfunction

	function automatic logic [COUNT_BITS-1:0] decode_gray(input logic [COUNT_BITS-1:0] g);
		logic [COUNT_BITS-1:0] b;
		int i;
		b[COUNT_BITS-1] = g[COUNT_BITS-1];
		for (i = COUNT_BITS - 2; i >= 0; i--) begin
			b[i] = b[i+1] ^ g[i];
		end
		return b;
	endfunction

	// Number of idle cycles before the next request or after a result.
	function automatic int draw_wait(input bit busy);
		return busy ? $urandom_range(0, 8) : 0;
	endfunction

	// One of the seven mapped register offsets.
	function automatic logic [ADDR_BITS-1:0] pick_offset();
		case ($urandom_range(0, 6))
			0: return OFF_CNT_LO;
			1: return OFF_CNT_HI;
			2: return OFF_CAP_LO;
			3: return OFF_CAP_HI;
			4: return OFF_MATCH_LO;
			5: return OFF_MATCH_HI;
			default: return OFF_CTRL;
		endcase
	endfunction

	task automatic report_failure(input string what);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("ERROR at %0t ns: %s", $time, what);
		end
	endtask

	task automatic reset_timer_state();
		tmr_count = '0;
		match_gray_lo = '1;
		match_gray_hi = '1;
		match_bin = decode_gray({match_gray_hi, match_gray_lo});
		flag = 1'b0;
		irq_en = 1'b0;
		armed = 1'b0;
	endtask

	// The compare is armed only while enabled and the match lies ahead.
	task automatic rearm_compare();
		armed = irq_en && (match_bin > tmr_count);
	endtask

	// Applies one accepted request to the predicted state and queues its result.
	task automatic predict_reply(input logic [1:0] req_op, input logic [ADDR_BITS-1:0] req_addr,
			input logic [WORD_BITS-1:0] req_wdata);
		timer_reply_t reply;
		logic [COUNT_BITS-1:0] gray;
		reply.data = '0;
		gray = binary_to_gray(tmr_count);
		case (req_op)
			OP_TICK: begin
				tmr_count = tmr_count + 1'b1;
				if (armed && tmr_count == match_bin) begin
					flag = 1'b1;
					armed = 1'b0;
				end
			end
			OP_READ: begin
				case (req_addr)
					OFF_CNT_LO:   reply.data = gray[31:0];
					OFF_CNT_HI:   reply.data = {{(WORD_BITS - HIGH_BITS){1'b0}}, gray[COUNT_BITS-1:32]};
					OFF_MATCH_LO: reply.data = match_gray_lo;
					OFF_MATCH_HI: reply.data = {{(WORD_BITS - HIGH_BITS){1'b0}}, match_gray_hi};
					OFF_CTRL: begin
						reply.data[CTRL_FLAG_BIT] = flag;
						reply.data[CTRL_EN_BIT] = irq_en;
					end
					default: reply.data = '0;
				endcase
			end
			OP_WRITE: begin
				case (req_addr)
					OFF_MATCH_LO: begin
						match_gray_lo = req_wdata;
						match_bin = decode_gray({match_gray_hi, match_gray_lo});
						rearm_compare();
					end
					OFF_MATCH_HI: begin
						match_gray_hi = req_wdata[HIGH_BITS-1:0];
						match_bin = decode_gray({match_gray_hi, match_gray_lo});
						rearm_compare();
					end
					OFF_CTRL: begin
						if (req_wdata[CTRL_FLAG_BIT]) begin
							flag = 1'b0;
						end
						irq_en = req_wdata[CTRL_EN_BIT];
						rearm_compare();
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		reply.irq = flag & irq_en;
		expected_replies.push_back(reply);
	endtask

	// Presents one request and returns at the edge that accepts it. Valid stays
	// high afterwards so that back-to-back requests need no second assignment.
	task automatic send_request(input logic [1:0] req_op, input logic [ADDR_BITS-1:0] req_addr,
			input logic [WORD_BITS-1:0] req_wdata);
		int gap;
		bit counts;
		gap = draw_wait(sender_busy);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= req_op;
		addr <= req_addr;
		wdata <= req_wdata;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		predict_reply(req_op, req_addr, req_wdata);

		// Only requests that touch the timer count towards the random total.
		case (req_addr)
			OFF_CNT_LO, OFF_CNT_HI, OFF_CAP_LO, OFF_CAP_HI: counts = (req_op == OP_READ);
			OFF_MATCH_LO, OFF_MATCH_HI, OFF_CTRL: counts = (req_op == OP_READ || req_op == OP_WRITE);
			default: counts = 1'b0;
		endcase
		if (req_op == OP_TICK || counts) begin
			useful_requests++;
		end
	endtask

	// Holds the input idle until every outstanding result has been returned.
	task automatic wait_for_replies();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_replies.size() != 0) @(posedge clk);
	endtask

	// Writes a match value in Gray code, in either order of the halves, with
	// random junk above the high half that the timer must drop.
	task automatic write_match(input logic [COUNT_BITS-1:0] target, input bit high_first);
		logic [COUNT_BITS-1:0] gray;
		logic [WORD_BITS-1:0] hi_word;
		gray = binary_to_gray(target);
		hi_word = $urandom;
		hi_word[HIGH_BITS-1:0] = gray[COUNT_BITS-1:32];
		if (high_first) begin
			send_request(OP_WRITE, OFF_MATCH_HI, hi_word);
			send_request(OP_WRITE, OFF_MATCH_LO, gray[31:0]);
		end else begin
			send_request(OP_WRITE, OFF_MATCH_LO, gray[31:0]);
			send_request(OP_WRITE, OFF_MATCH_HI, hi_word);
		end
	endtask

	// Results are checked at every accepted edge, then the output stalls at random.
	initial begin : reply_checker
		timer_reply_t want;
		int hold;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				replies_checked++;
				if (expected_replies.size() == 0) begin
					report_failure($sformatf("result %0d with no request outstanding: read_data %08h",
						replies_checked, read_data));
				end else begin
					want = expected_replies.pop_front();
					if (read_data !== want.data || irq_level !== want.irq) begin
						report_failure($sformatf(
							"result %0d: read_data expected %08h got %08h, irq_level expected %0b got %0b",
							replies_checked, want.data, read_data, want.irq, irq_level));
					end
				end
				hold = draw_wait(receiver_busy);
				if (hold > 0) begin
					out_stall <= 1'b1;
					repeat (hold) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	// Every register straight after reset, unmapped and misaligned offsets, and
	// the unused operation code.
	task automatic test_reset_readback();
		send_request(OP_READ, OFF_CNT_LO, '0);
		send_request(OP_READ, OFF_CNT_HI, '0);
		send_request(OP_READ, OFF_CAP_LO, '0);
		send_request(OP_READ, OFF_CAP_HI, '0);
		send_request(OP_READ, OFF_MATCH_LO, '0);
		send_request(OP_READ, OFF_MATCH_HI, '0);
		send_request(OP_READ, OFF_CTRL, '0);
		send_request(OP_READ, 12'h018, '0);
		send_request(OP_READ, 12'h001, '1);
		send_request(OP_UNUSED, 12'hFFF, '1);
	endtask

	// Writes to read-only, capture, unmapped and misaligned offsets change nothing.
	task automatic test_ignored_writes();
		send_request(OP_WRITE, OFF_CNT_LO, '1);
		send_request(OP_WRITE, OFF_CNT_HI, '1);
		send_request(OP_WRITE, OFF_CAP_LO, '1);
		send_request(OP_WRITE, OFF_CAP_HI, '1);
		send_request(OP_WRITE, 12'h011, '0);
		send_request(OP_WRITE, 12'hFFF, '0);
		send_request(OP_READ, OFF_CNT_LO, '0);
		send_request(OP_READ, OFF_MATCH_LO, '0);
	endtask

	// The compare fires, the flag survives a disable, clears on a write of one,
	// and a match equal to the count does not arm. The counter cannot be loaded,
	// so its wrap at the full width lies out of reach of a run of ticks.
	task automatic test_match_event();
		logic [WORD_BITS-1:0] ctl;
		ctl = '0;
		ctl[CTRL_EN_BIT] = 1'b1;
		send_request(OP_WRITE, OFF_CTRL, ctl);
		write_match(tmr_count + 2, 1'b1);
		send_request(OP_TICK, '0, '0);
		send_request(OP_TICK, '1, '1);
		send_request(OP_READ, OFF_CTRL, '0);
		send_request(OP_WRITE, OFF_CTRL, '0);
		send_request(OP_WRITE, OFF_CTRL, ctl);
		ctl[CTRL_FLAG_BIT] = 1'b1;
		send_request(OP_WRITE, OFF_CTRL, ctl);
		send_request(OP_TICK, '0, '0);
		write_match(tmr_count, 1'b0);
		send_request(OP_TICK, '0, '0);
		send_request(OP_READ, OFF_MATCH_HI, '0);
	endtask

	// Enable, aim the match a few ticks ahead (sometimes behind), tick past it
	// with reads in between, then look at and perhaps clear the flag.
	task automatic run_match_sequence();
		logic [WORD_BITS-1:0] ctl;
		logic [COUNT_BITS-1:0] target;
		int ticks;
		ctl = $urandom;
		ctl[CTRL_EN_BIT] = ($urandom_range(0, 5) != 0);
		send_request(OP_WRITE, OFF_CTRL, ctl);
		if ($urandom_range(0, 3) == 0) begin
			target = tmr_count - $urandom_range(0, 3);
		end else begin
			target = tmr_count + $urandom_range(0, 10);
		end
		write_match(target, 1'($urandom_range(0, 1)));
		ticks = $urandom_range(0, 14);
		repeat (ticks) begin
			if ($urandom_range(0, 3) == 0) begin
				send_request(OP_READ, pick_offset(), $urandom);
			end
			send_request(OP_TICK, ADDR_BITS'($urandom_range(0, 4095)), $urandom);
		end
		send_request(OP_READ, OFF_CTRL, $urandom);
		if ($urandom_range(0, 1)) begin
			ctl = $urandom;
			ctl[CTRL_FLAG_BIT] = 1'b1;
			send_request(OP_WRITE, OFF_CTRL, ctl);
		end
	endtask

	// Mostly well-formed match sequences, plus lone accesses and raw noise,
	// with the pacing of both channels changing from stretch to stretch.
	task automatic test_random_traffic();
		int goal;
		int next_pace;
		int choice;
		bit drained;
		goal = useful_requests + RANDOM_REQUESTS;
		next_pace = 0;
		drained = 1'b0;
		while (useful_requests < goal) begin
			if (useful_requests >= next_pace) begin
				sender_busy = ($urandom_range(0, 3) != 0);
				receiver_busy = ($urandom_range(0, 3) != 0);
				next_pace = useful_requests + $urandom_range(50, 200);
			end
			if (!drained && useful_requests >= goal - RANDOM_REQUESTS / 2) begin
				wait_for_replies();
				drained = 1'b1;
			end
			choice = $urandom_range(0, 99);
			if (choice < 50) begin
				run_match_sequence();
			end else if (choice < 70) begin
				send_request(OP_TICK, ADDR_BITS'($urandom_range(0, 4095)), $urandom);
			end else if (choice < 88) begin
				send_request($urandom_range(0, 1) ? OP_READ : OP_WRITE, pick_offset(), $urandom);
			end else begin
				send_request(2'($urandom_range(0, 3)), ADDR_BITS'($urandom_range(0, 4095)),
					$urandom);
			end
		end
	endtask

	// Reset, then the tests in turn, each run to completion before the next.
	initial begin
		reset_timer_state();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_readback();
		wait_for_replies();
		test_ignored_writes();
		wait_for_replies();
		test_match_event();
		wait_for_replies();
		test_random_traffic();
		wait_for_replies();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_replies.size() != 0) begin
			report_failure($sformatf("%0d results never arrived", expected_replies.size()));
		end
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== gray_coded_event_timer.f =====
rtl/core/gcet_pkg.sv
rtl/core/gcet_core.sv
rtl/core/gray_coded_event_timer.sv
test/testbench.sv
